>>> hdl/vpcc_pkg.sv
// Shared types, constants and register offsets of the VirtIO common-config register file.
package vpcc_pkg;

   // Number of virtqueues (range 1 to 64).
   localparam int QUEUE_COUNT = 4;
   localparam int QIDX_W      = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

   // Access kinds
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_FEAT_LO = 2'd0;
   localparam logic [1:0] CSR_FEAT_HI = 2'd1;
   localparam logic [1:0] CSR_QMAX    = 2'd2;

   localparam logic [31:0] CSR_FEAT_RESET = 32'h0000_0000;
   localparam logic [15:0] CSR_QMAX_RESET = 16'h0100;

   // BAR 0 regions, taken from offset bits [11:8]
   localparam logic [3:0] REGION_COMMON = 4'h0;
   localparam logic [3:0] REGION_NOTIFY = 4'h1;
   localparam logic [3:0] REGION_ISR    = 4'h2;

   // Common region register offsets
   localparam logic [7:0] OFF_DEV_FSEL    = 8'h00;
   localparam logic [7:0] OFF_DEV_FEAT    = 8'h04;
   localparam logic [7:0] OFF_DRV_FSEL    = 8'h08;
   localparam logic [7:0] OFF_DRV_FEAT    = 8'h0C;
   localparam logic [7:0] OFF_MSIX_CFG    = 8'h10;
   localparam logic [7:0] OFF_QUEUE_COUNT = 8'h12;
   localparam logic [7:0] OFF_STATUS      = 8'h14;
   localparam logic [7:0] OFF_CFG_GEN     = 8'h15;
   localparam logic [7:0] OFF_QSEL        = 8'h16;
   localparam logic [7:0] OFF_QSIZE       = 8'h18;
   localparam logic [7:0] OFF_QMSIX       = 8'h1A;
   localparam logic [7:0] OFF_QENABLE     = 8'h1C;
   localparam logic [7:0] OFF_QNOTIFY     = 8'h1E;
   localparam logic [7:0] OFF_QDESC_LO    = 8'h20;
   localparam logic [7:0] OFF_QDESC_HI    = 8'h24;
   localparam logic [7:0] OFF_QAVAIL_LO   = 8'h28;
   localparam logic [7:0] OFF_QAVAIL_HI   = 8'h2C;
   localparam logic [7:0] OFF_QUSED_LO    = 8'h30;
   localparam logic [7:0] OFF_QUSED_HI    = 8'h34;

   localparam logic [31:0] NO_VECTOR = 32'h0000_FFFF;

   typedef enum logic [1:0] {
      RING_DESC,
      RING_AVAIL,
      RING_USED
   } ring_type;

   typedef struct packed {
      logic        func;
      logic [2:0]  bar_index;
      logic [11:0] reg_offset;
      logic [31:0] write_data;
      logic [1:0]  isr_set;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        notify_valid;
      logic [15:0] notify_queue;
      logic        features_written;
      logic [31:0] features_word_select;
      logic        reset_event;
   } rsp_type;

   typedef struct packed {
      logic [31:0] feat_lo;
      logic [31:0] feat_hi;
      logic [15:0] qmax;
   } cfg_type;

   // Register contents as seen by the decoder; per-queue fields belong to the
   // selected queue and read 0 when it is out of range.
   typedef struct packed {
      logic [31:0] dev_fsel;
      logic [31:0] drv_fsel;
      logic [31:0] drv_fbits;
      logic [7:0]  status;
      logic [7:0]  isr;
      logic [15:0] sel_queue;
      logic        qok;
      logic [15:0] q_enable;
      logic [63:0] q_desc;
      logic [63:0] q_avail;
      logic [63:0] q_used;
   } view_type;

   // Register updates decided for one access.
   typedef struct packed {
      logic        en;
      logic [31:0] data;
      logic [7:0]  isr;
      logic        wr_dev_fsel;
      logic        wr_drv_fsel;
      logic        wr_drv_fbits;
      logic        wr_status;
      logic        dev_reset;
      logic        wr_qsel;
      logic        wr_qenable;
      logic        wr_addr;
      ring_type    addr_ring;
      logic        addr_hi;
   } upd_type;

endpackage

>>> hdl/virtio_pci_common_config_regs_core.sv
// Top level of the VirtIO modern PCI common-config register file behind BAR 0.
// Pipeline: an accepted transfer is registered in the input stage and then in the result
//   register, which drives rsp_valid and rsp_data.
// Throughput: one transfer per cycle; busy stays low, and rsp has no back-pressure.
// Reset: synchronous, active high; clears the valid flags and the register state, drops
//   any transfer in flight and reloads the configuration registers with their defaults.
module virtio_pci_common_config_regs_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vpcc_pkg::req_type req_data,
   output logic              rsp_valid,
   output vpcc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import vpcc_pkg::*;

   // Configuration registers
   logic [31:0] feat_lo_ff;
   logic [31:0] feat_hi_ff;
   logic [15:0] qmax_ff;
   cfg_type     cfg;

   // Input stage
   logic        req_valid_ff;
   req_type     req_ff;

   // Result stage
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   view_type    view;
   upd_type     upd;

   // Every access decodes in one pass, so the block never holds off a transfer.
   assign busy = 1'b0;

   // Plain write port: take the write at the edge, ignore unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         feat_lo_ff <= CSR_FEAT_RESET;
         feat_hi_ff <= CSR_FEAT_RESET;
         qmax_ff    <= CSR_QMAX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FEAT_LO: feat_lo_ff <= csr_wdata;
            CSR_FEAT_HI: feat_hi_ff <= csr_wdata;
            CSR_QMAX:    qmax_ff    <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.feat_lo = feat_lo_ff;
   assign cfg.feat_hi = feat_hi_ff;
   assign cfg.qmax    = qmax_ff;

   // Capture the transfer; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   // Decode against the current register contents. The state update lands at
   // the same edge that loads the result, so the next transfer in the input
   // stage already sees it.
   vpcc_decode u_decode (
      .en   (req_valid_ff),
      .req  (req_ff),
      .cfg  (cfg),
      .view (view),
      .rsp  (rsp_in),
      .upd  (upd)
   );

   vpcc_state u_state (
      .clock (clock),
      .reset (reset),
      .upd   (upd),
      .view  (view)
   );

   // Result register: strobe for one cycle, receiver takes it unconditionally.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/vpcc_state.sv
// Architectural registers of the common-config space and per-queue state.
module vpcc_state (
   input  logic               clock,
   input  logic               reset,
   input  vpcc_pkg::upd_type  upd,
   output vpcc_pkg::view_type view
);
   import vpcc_pkg::*;

   logic [31:0]       dev_fsel_ff;
   logic [31:0]       drv_fsel_ff;
   logic [31:0]       drv_fbits_ff;
   logic [7:0]        status_ff;
   logic [7:0]        isr_ff;
   logic [15:0]       sel_queue_ff;
   logic [15:0]       qen_ff   [QUEUE_COUNT];
   logic [63:0]       desc_ff  [QUEUE_COUNT];
   logic [63:0]       avail_ff [QUEUE_COUNT];
   logic [63:0]       used_ff  [QUEUE_COUNT];
   logic              qok;
   logic [QIDX_W-1:0] qidx;

   assign qok  = sel_queue_ff < 16'(QUEUE_COUNT);
   assign qidx = qok ? sel_queue_ff[QIDX_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_fsel_ff  <= '0;
         drv_fsel_ff  <= '0;
         drv_fbits_ff <= '0;
         status_ff    <= '0;
         isr_ff       <= '0;
         sel_queue_ff <= '0;
      end else if (upd.en) begin
         isr_ff <= upd.isr;
         if (upd.wr_qsel) begin
            sel_queue_ff <= upd.data[15:0];
         end
         if (upd.dev_reset) begin
            dev_fsel_ff  <= '0;
            drv_fsel_ff  <= '0;
            drv_fbits_ff <= '0;
            status_ff    <= '0;
         end else begin
            if (upd.wr_dev_fsel)  dev_fsel_ff  <= upd.data;
            if (upd.wr_drv_fsel)  drv_fsel_ff  <= upd.data;
            if (upd.wr_drv_fbits) drv_fbits_ff <= upd.data;
            if (upd.wr_status)    status_ff    <= upd.data[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int q = 0; q < QUEUE_COUNT; q++) begin
         if (reset || (upd.en && upd.dev_reset)) begin
            qen_ff[q]   <= '0;
            desc_ff[q]  <= '0;
            avail_ff[q] <= '0;
            used_ff[q]  <= '0;
         end else if (upd.en && QIDX_W'(q) == qidx) begin
            if (upd.wr_qenable) begin
               qen_ff[q] <= upd.data[15:0];
            end
            if (upd.wr_addr) begin
               unique case (upd.addr_ring)
                  RING_DESC: begin
                     if (upd.addr_hi) desc_ff[q][63:32] <= upd.data;
                     else             desc_ff[q][31:0]  <= upd.data;
                  end
                  RING_AVAIL: begin
                     if (upd.addr_hi) avail_ff[q][63:32] <= upd.data;
                     else             avail_ff[q][31:0]  <= upd.data;
                  end
                  RING_USED: begin
                     if (upd.addr_hi) used_ff[q][63:32] <= upd.data;
                     else             used_ff[q][31:0]  <= upd.data;
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      view.dev_fsel  = dev_fsel_ff;
      view.drv_fsel  = drv_fsel_ff;
      view.drv_fbits = drv_fbits_ff;
      view.status    = status_ff;
      view.isr       = isr_ff;
      view.sel_queue = sel_queue_ff;
      view.qok       = qok;
      view.q_enable  = qok ? qen_ff[qidx]   : '0;
      view.q_desc    = qok ? desc_ff[qidx]  : '0;
      view.q_avail   = qok ? avail_ff[qidx] : '0;
      view.q_used    = qok ? used_ff[qidx]  : '0;
   end

endmodule

>>> hdl/vpcc_decode.sv
// Access decoder: read mux, register update controls and event flags for one transfer.
module vpcc_decode (
   input  logic               en,
   input  vpcc_pkg::req_type  req,
   input  vpcc_pkg::cfg_type  cfg,
   input  vpcc_pkg::view_type view,
   output vpcc_pkg::rsp_type  rsp,
   output vpcc_pkg::upd_type  upd
);
   import vpcc_pkg::*;

   logic [3:0] region;
   logic [7:0] off;
   logic [7:0] isr_cur;

   assign region  = req.reg_offset[11:8];
   assign off     = req.reg_offset[7:0];
   assign isr_cur = view.isr | {6'b0, req.isr_set};

   always_comb begin
      rsp       = '0;
      upd       = '0;
      upd.en    = en;
      upd.data  = req.write_data;
      upd.isr   = isr_cur;
      upd.addr_ring = RING_DESC;

      if (req.bar_index == 3'd0) begin
         if (req.func == FUNC_READ) begin
            if (region == REGION_COMMON) begin
               unique case (off)
                  OFF_DEV_FSEL: rsp.read_data = view.dev_fsel;
                  OFF_DEV_FEAT: begin
                     if (view.dev_fsel == 32'd0)      rsp.read_data = cfg.feat_lo;
                     else if (view.dev_fsel == 32'd1) rsp.read_data = cfg.feat_hi;
                  end
                  OFF_DRV_FSEL:    rsp.read_data = view.drv_fsel;
                  OFF_DRV_FEAT:    rsp.read_data = view.drv_fbits;
                  OFF_MSIX_CFG:    rsp.read_data = NO_VECTOR;
                  OFF_QUEUE_COUNT: rsp.read_data = 32'(QUEUE_COUNT);
                  OFF_STATUS:      rsp.read_data = {24'b0, view.status};
                  OFF_CFG_GEN:     rsp.read_data = '0;
                  OFF_QSEL:        rsp.read_data = {16'b0, view.sel_queue};
                  OFF_QSIZE:       rsp.read_data = view.qok ? {16'b0, cfg.qmax} : '0;
                  OFF_QMSIX:       rsp.read_data = NO_VECTOR;
                  OFF_QENABLE:     rsp.read_data = {16'b0, view.q_enable};
                  OFF_QNOTIFY:     rsp.read_data = {16'b0, view.sel_queue};
                  OFF_QDESC_LO:    rsp.read_data = view.q_desc[31:0];
                  OFF_QDESC_HI:    rsp.read_data = view.q_desc[63:32];
                  OFF_QAVAIL_LO:   rsp.read_data = view.q_avail[31:0];
                  OFF_QAVAIL_HI:   rsp.read_data = view.q_avail[63:32];
                  OFF_QUSED_LO:    rsp.read_data = view.q_used[31:0];
                  OFF_QUSED_HI:    rsp.read_data = view.q_used[63:32];
                  default:         rsp.read_data = '0;
               endcase
            end else if (region == REGION_ISR) begin
               // read returns the merged status and clears it
               rsp.read_data = {24'b0, isr_cur};
               upd.isr       = '0;
            end
         end else if (region == REGION_COMMON) begin
            unique case (off)
               OFF_DEV_FSEL: upd.wr_dev_fsel = 1'b1;
               OFF_DRV_FSEL: upd.wr_drv_fsel = 1'b1;
               OFF_DRV_FEAT: begin
                  upd.wr_drv_fbits         = 1'b1;
                  rsp.features_written     = 1'b1;
                  rsp.features_word_select = view.drv_fsel;
               end
               OFF_STATUS: begin
                  upd.wr_status = 1'b1;
                  if (req.write_data[7:0] == 8'd0) begin
                     upd.dev_reset   = 1'b1;
                     upd.isr         = '0;
                     rsp.reset_event = 1'b1;
                  end
               end
               OFF_QSEL:    upd.wr_qsel    = 1'b1;
               OFF_QENABLE: upd.wr_qenable = view.qok;
               OFF_QDESC_LO, OFF_QDESC_HI: begin
                  upd.wr_addr   = view.qok;
                  upd.addr_ring = RING_DESC;
                  upd.addr_hi   = (off == OFF_QDESC_HI);
               end
               OFF_QAVAIL_LO, OFF_QAVAIL_HI: begin
                  upd.wr_addr   = view.qok;
                  upd.addr_ring = RING_AVAIL;
                  upd.addr_hi   = (off == OFF_QAVAIL_HI);
               end
               OFF_QUSED_LO, OFF_QUSED_HI: begin
                  upd.wr_addr   = view.qok;
                  upd.addr_ring = RING_USED;
                  upd.addr_hi   = (off == OFF_QUSED_HI);
               end
               default: begin
               end
            endcase
         end else if (region == REGION_NOTIFY) begin
            rsp.notify_valid = 1'b1;
            rsp.notify_queue = req.write_data[15:0];
         end
      end
   end

endmodule

>>> hdl/vpcc_checker.sv
// Port-level checker for the register file, bound to the top level.
module vpcc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input vpcc_pkg::rsp_type rsp_data,
   input logic              rsp_valid
);
   import vpcc_pkg::*;

   // Each result traces back to an accepted transfer through the input and result stages.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without a matching transfer");

   // No transfer is lost once reset has been low for the whole trip.
   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(reset, 2) && $past(start && !busy, 2)) |-> rsp_valid)
      else $error("transfer produced no result");

   // One access raises at most one event, and events come with zero read data.
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($onehot0({rsp_data.notify_valid, rsp_data.features_written,
                               rsp_data.reset_event})
                     && ((rsp_data.notify_valid || rsp_data.features_written ||
                          rsp_data.reset_event) ? rsp_data.read_data == 32'd0 : 1'b1)))
      else $error("conflicting events in one result");

   // Side fields stay zero when their event is absent.
   a_side_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.notify_valid || rsp_data.notify_queue == 16'd0)
                     && (rsp_data.features_written ||
                         rsp_data.features_word_select == 32'd0)))
      else $error("side field set without its event");

endmodule

bind virtio_pci_common_config_regs_core vpcc_checker u_vpcc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);

>>> sim/vpcc_regs_checker.sv
// Checker for the VirtIO common-config register file: predicts each transfer and compares results.
`timescale 1ns / 100ps

module vpcc_regs_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  vpcc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  vpcc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output int                mismatch_count,
   output int                pending_count
);

   import vpcc_pkg::*;

   // Configuration copy
   logic [31:0] feat_lo;
   logic [31:0] feat_hi;
   logic [15:0] qmax;

   // Register file copy; queue sizes are read-only, come from qmax and are not tracked
   logic [31:0] dev_fsel;
   logic [31:0] drv_fsel;
   logic [31:0] drv_fbits;
   logic [7:0]  status_reg;
   logic [7:0]  isr_reg;
   logic [15:0] sel_queue;
   logic [15:0] q_enable [QUEUE_COUNT];
   logic [63:0] q_desc   [QUEUE_COUNT];
   logic [63:0] q_avail  [QUEUE_COUNT];
   logic [63:0] q_used   [QUEUE_COUNT];

   rsp_type predicted_rsp_q [$];
   int      errors = 0;
   int      in_flight = 0;

   assign mismatch_count = errors;
   assign pending_count  = in_flight;

   // Device reset: selected queue survives
   function void clear_device();
      status_reg = '0;
      isr_reg    = '0;
      drv_fbits  = '0;
      drv_fsel   = '0;
      dev_fsel   = '0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
         q_enable[i] = '0;
         q_desc[i]   = '0;
         q_avail[i]  = '0;
         q_used[i]   = '0;
      end
   endfunction

   function logic [31:0] common_read(input logic [7:0] off);
      logic              qok;
      logic [QIDX_W-1:0] q;
      qok = (sel_queue < QUEUE_COUNT);
      q   = sel_queue[QIDX_W-1:0];
      case (off)
         OFF_DEV_FSEL:    return dev_fsel;
         OFF_DEV_FEAT:    return (dev_fsel == 32'd0) ? feat_lo :
                                 (dev_fsel == 32'd1) ? feat_hi : 32'd0;
         OFF_DRV_FSEL:    return drv_fsel;
         OFF_DRV_FEAT:    return drv_fbits;
         OFF_MSIX_CFG:    return NO_VECTOR;
         OFF_QUEUE_COUNT: return 32'(QUEUE_COUNT & 16'hFFFF);
         OFF_STATUS:      return {24'd0, status_reg};
         OFF_CFG_GEN:     return 32'd0;
         OFF_QSEL:        return {16'd0, sel_queue};
         OFF_QSIZE:       return qok ? {16'd0, qmax} : 32'd0;
         OFF_QMSIX:       return NO_VECTOR;
         OFF_QENABLE:     return qok ? {16'd0, q_enable[q]} : 32'd0;
         OFF_QNOTIFY:     return {16'd0, sel_queue};
         OFF_QDESC_LO:    return qok ? q_desc[q][31:0] : 32'd0;
         OFF_QDESC_HI:    return qok ? q_desc[q][63:32] : 32'd0;
         OFF_QAVAIL_LO:   return qok ? q_avail[q][31:0] : 32'd0;
         OFF_QAVAIL_HI:   return qok ? q_avail[q][63:32] : 32'd0;
         OFF_QUSED_LO:    return qok ? q_used[q][31:0] : 32'd0;
         OFF_QUSED_HI:    return qok ? q_used[q][63:32] : 32'd0;
         default:         return 32'd0;
      endcase
   endfunction

   // Apply one bus access to the register copy and return its result
   function rsp_type decode_access(input req_type r);
      rsp_type           res;
      logic              qok;
      logic [QIDX_W-1:0] q;
      logic [3:0]        region;
      logic [7:0]        off;
      res    = '0;
      qok    = (sel_queue < QUEUE_COUNT);
      q      = sel_queue[QIDX_W-1:0];
      region = r.reg_offset[11:8];
      off    = r.reg_offset[7:0];
      // merge side-band causes ahead of the decode
      isr_reg = isr_reg | {6'd0, r.isr_set};
      if (r.bar_index == 3'd0) begin
         if (r.func == FUNC_READ) begin
            if (region == REGION_COMMON) begin
               res.read_data = common_read(off);
            end else if (region == REGION_ISR) begin
               res.read_data = {24'd0, isr_reg};
               isr_reg       = '0;
            end
         end else if (region == REGION_COMMON) begin
            case (off)
               OFF_DEV_FSEL: dev_fsel = r.write_data;
               OFF_DRV_FSEL: drv_fsel = r.write_data;
               OFF_DRV_FEAT: begin
                  drv_fbits                = r.write_data;
                  res.features_written     = 1'b1;
                  res.features_word_select = drv_fsel;
               end
               OFF_STATUS: begin
                  status_reg = r.write_data[7:0];
                  if (status_reg == 8'd0) begin
                     clear_device();
                     res.reset_event = 1'b1;
                  end
               end
               OFF_QSEL:      sel_queue = r.write_data[15:0];
               OFF_QENABLE:   if (qok) q_enable[q] = r.write_data[15:0];
               OFF_QDESC_LO:  if (qok) q_desc[q][31:0]   = r.write_data;
               OFF_QDESC_HI:  if (qok) q_desc[q][63:32]  = r.write_data;
               OFF_QAVAIL_LO: if (qok) q_avail[q][31:0]  = r.write_data;
               OFF_QAVAIL_HI: if (qok) q_avail[q][63:32] = r.write_data;
               OFF_QUSED_LO:  if (qok) q_used[q][31:0]   = r.write_data;
               OFF_QUSED_HI:  if (qok) q_used[q][63:32]  = r.write_data;
               default: ;
            endcase
         end else if (region == REGION_NOTIFY) begin
            res.notify_valid = 1'b1;
            res.notify_queue = r.write_data[15:0];
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         if (errors <= 10)
            $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         feat_lo   = CSR_FEAT_RESET;
         feat_hi   = CSR_FEAT_RESET;
         qmax      = CSR_QMAX_RESET;
         sel_queue = '0;
         clear_device();
         predicted_rsp_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FEAT_LO: feat_lo = csr_wdata;
               CSR_FEAT_HI: feat_hi = csr_wdata;
               CSR_QMAX:    qmax    = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (predicted_rsp_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result with no transfer outstanding: %h", $time, rsp_data);
            end else begin
               want = predicted_rsp_q.pop_front();
               check_field("read_data", want.read_data, rsp_data.read_data);
               check_field("notify_valid", 32'(want.notify_valid), 32'(rsp_data.notify_valid));
               check_field("notify_queue", 32'(want.notify_queue), 32'(rsp_data.notify_queue));
               check_field("features_written", 32'(want.features_written),
                           32'(rsp_data.features_written));
               check_field("features_word_select", want.features_word_select,
                           rsp_data.features_word_select);
               check_field("reset_event", 32'(want.reset_event), 32'(rsp_data.reset_event));
            end
         end
         if (start && !busy)
            predicted_rsp_q.push_back(decode_access(req_data));
      end
      in_flight = predicted_rsp_q.size();
   end

endmodule

>>> sim/tb.sv
// Testbench top for the VirtIO common-config register file: stimulus, checker and verdict.
`timescale 1ns / 100ps

module tb;

   import vpcc_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;
   int          mismatch_count;
   int          pending_count;

   virtio_pci_common_config_regs_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // The checker watches both channels and the CSR port on its own
   vpcc_regs_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic req_type access(input logic f, input logic [2:0] bar,
                                      input logic [11:0] off, input logic [31:0] data,
                                      input logic [1:0] isr);
      req_type r;
      r.func       = f;
      r.bar_index  = bar;
      r.reg_offset = off;
      r.write_data = data;
      r.isr_set    = isr;
      return r;
   endfunction

   function automatic logic [7:0] pick_common_offset();
      case ($urandom_range(0, 18))
         0:  return OFF_DEV_FSEL;
         1:  return OFF_DEV_FEAT;
         2:  return OFF_DRV_FSEL;
         3:  return OFF_DRV_FEAT;
         4:  return OFF_MSIX_CFG;
         5:  return OFF_QUEUE_COUNT;
         6:  return OFF_STATUS;
         7:  return OFF_CFG_GEN;
         8:  return OFF_QSEL;
         9:  return OFF_QSIZE;
         10: return OFF_QMSIX;
         11: return OFF_QENABLE;
         12: return OFF_QNOTIFY;
         13: return OFF_QDESC_LO;
         14: return OFF_QDESC_HI;
         15: return OFF_QAVAIL_LO;
         16: return OFF_QAVAIL_HI;
         17: return OFF_QUSED_LO;
         default: return OFF_QUSED_HI;
      endcase
   endfunction

   // Mostly decoded register traffic on BAR 0; the rest is notify, ISR and raw noise
   function automatic req_type make_access();
      req_type r;
      int      kind;
      r.func       = 1'($urandom_range(0, 1));
      r.bar_index  = 3'd0;
      r.write_data = $urandom();
      r.isr_set    = 2'($urandom_range(0, 3));
      kind         = $urandom_range(0, 99);
      if (kind < 70) begin
         r.reg_offset = {REGION_COMMON, pick_common_offset()};
         if (r.func == FUNC_WRITE) begin
            case (r.reg_offset[7:0])
               // keep the selected queue mostly in range
               OFF_QSEL:
                  if ($urandom_range(0, 9) != 0)
                     r.write_data = $urandom_range(0, QUEUE_COUNT - 1);
               OFF_DEV_FSEL:
                  if ($urandom_range(0, 3) != 0)
                     r.write_data = $urandom_range(0, 1);
               // device reset is rare so that queue addresses build up
               OFF_STATUS:
                  if ($urandom_range(0, 15) == 0)
                     r.write_data[7:0] = 8'h00;
                  else if (r.write_data[7:0] == 8'h00)
                     r.write_data[7:0] = 8'h01;
               default: ;
            endcase
         end
      end else if (kind < 80) begin
         r.reg_offset = {REGION_NOTIFY, 8'($urandom())};
         if ($urandom_range(0, 3) != 0)
            r.func = FUNC_WRITE;
      end else if (kind < 88) begin
         r.reg_offset = {REGION_ISR, 8'($urandom())};
         if ($urandom_range(0, 3) != 0)
            r.func = FUNC_READ;
      end else begin
         r.reg_offset = 12'($urandom_range(0, 4095));
         r.bar_index  = 3'($urandom_range(0, 7));
      end
      return r;
   endfunction

   // Present one transfer and hold it until accepted; return at the next falling edge
   task automatic send(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      do
         @(posedge clock);
      while (busy);
      @(negedge clock);
   endtask

   // Drop start and wait until every transfer has come back
   task automatic drain();
      start <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Load all three CSRs on consecutive cycles; call only while idle
   task automatic load_config(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [15:0] qm);
      csr_we    <= 1'b1;
      csr_index <= CSR_FEAT_LO;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= CSR_FEAT_HI;
      csr_wdata <= hi;
      @(negedge clock);
      csr_index <= CSR_QMAX;
      csr_wdata <= {16'd0, qm};
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Random traffic in bursts; some bursts run back to back with no gap
   task automatic run_random(input int count);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            send(make_access());
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_FEAT_LO;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pass under distinct feature words and the reset queue size
      load_config(32'h89AB_CDEF, 32'h0123_4567, CSR_QMAX_RESET);
      send(access(FUNC_READ,  3'd0, {REGION_COMMON, OFF_QUEUE_COUNT}, 32'd0, 2'd0));
      send(access(FUNC_READ,  3'd0, {REGION_COMMON, OFF_MSIX_CFG}, 32'd0, 2'd1));
      send(access(FUNC_READ,  3'd0, {REGION_COMMON, OFF_QMSIX}, 32'd0, 2'd0));
      send(access(FUNC_READ,  3'd0, {REGION_COMMON, OFF_CFG_GEN}, 32'd0, 2'd0));
      // device feature select 0, 1 and out of range
      send(access(FUNC_READ,  3'd0, {REGION_COMMON, OFF_DEV_FEAT}, 32'd0, 2'd0));
      send(access(FUNC_WRITE, 3'd0, {REGION_COMMON, OFF_DEV_FSEL}, 32'd1, 2'd0));
      send(access(FUNC_READ,  3'd0, {REGION_COMMON, OFF_DEV_FEAT}, 32'd0, 2'd0));
      send(access(FUNC_WRITE, 3'd0, {REGION_COMMON, OFF_DEV_FSEL}, 32'hFFFF_FFFF, 2'd0));
      send(access(FUNC_READ,  3'd0, {REGION_COMMON, OFF_DEV_FEAT}, 32'd0, 2'd0));
      // driver features write reports the select that goes with it
      send(access(FUNC_WRITE, 3'd0, {REGION_COMMON, OFF_DRV_FSEL}, 32'hFFFF_FFFF, 2'd0));
      send(access(FUNC_WRITE, 3'd0, {REGION_COMMON, OFF_DRV_FEAT}, 32'hFFFF_FFFF, 2'd0));
      // only the status low byte sticks
      send(access(FUNC_WRITE, 3'd0, {REGION_COMMON, OFF_STATUS}, 32'hFFFF_FFFF, 2'd0));
      // last in-range queue, then far out of range
      send(access(FUNC_WRITE, 3'd0, {REGION_COMMON, OFF_QSEL}, QUEUE_COUNT - 1, 2'd0));
      send(access(FUNC_WRITE, 3'd0, {REGION_COMMON, OFF_QDESC_HI}, 32'hFFFF_FFFF, 2'd0));
      send(access(FUNC_READ,  3'd0, {REGION_COMMON, OFF_QDESC_HI}, 32'd0, 2'd0));
      send(access(FUNC_WRITE, 3'd0, {REGION_COMMON, OFF_QENABLE}, 32'hFFFF_FFFF, 2'd0));
      send(access(FUNC_READ,  3'd0, {REGION_COMMON, OFF_QENABLE}, 32'd0, 2'd0));
      send(access(FUNC_WRITE, 3'd0, {REGION_COMMON, OFF_QSEL}, 32'hFFFF_FFFF, 2'd0));
      send(access(FUNC_READ,  3'd0, {REGION_COMMON, OFF_QSIZE}, 32'd0, 2'd0));
      send(access(FUNC_READ,  3'd0, {REGION_COMMON, OFF_QNOTIFY}, 32'd0, 2'd0));
      // notify at the top of its region; ISR read sees causes merged in the same access
      send(access(FUNC_WRITE, 3'd0, 12'h1FF, 32'hFFFF_FFFF, 2'd0));
      send(access(FUNC_READ,  3'd0, 12'h2FF, 32'd0, 2'd3));
      // other BARs are ignored but still merge interrupt causes
      send(access(FUNC_WRITE, 3'd7, {REGION_COMMON, OFF_STATUS}, 32'd0, 2'd2));
      send(access(FUNC_READ,  3'd5, 12'h200, 32'd0, 2'd0));
      send(access(FUNC_READ,  3'd0, 12'h200, 32'd0, 2'd0));
      // unaligned and top-of-BAR reads return zero
      send(access(FUNC_READ,  3'd0, 12'h021, 32'd0, 2'd0));
      send(access(FUNC_READ,  3'd0, 12'hFFF, 32'd0, 2'd0));
      // status write with a zero low byte resets the device but keeps the queue select
      send(access(FUNC_WRITE, 3'd0, {REGION_COMMON, OFF_STATUS}, 32'h0000_0100, 2'd0));
      send(access(FUNC_READ,  3'd0, {REGION_COMMON, OFF_QSEL}, 32'd0, 2'd0));
      drain();

      // Random phases across CSR extremes and random settings
      load_config(32'd0, 32'd0, 16'd0);
      run_random(190);
      drain();
      load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      run_random(190);
      drain();
      load_config($urandom(), $urandom(), 16'($urandom()));
      run_random(190);
      drain();
      load_config($urandom(), $urandom(), 16'($urandom()));
      run_random(190);
      drain();
      repeat (10) @(negedge clock);

      if (mismatch_count == 0 && pending_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> sim.f
hdl/vpcc_pkg.sv
hdl/vpcc_state.sv
hdl/vpcc_decode.sv
hdl/virtio_pci_common_config_regs_core.sv
hdl/vpcc_checker.sv
sim/vpcc_regs_checker.sv
sim/tb.sv
